### design/cpg_pkg.sv
// ---------------------------------------------------------------------------
// cpg_pkg
// Shared types and constants of the chained periodic gather block.
// ---------------------------------------------------------------------------
package cpg_pkg;

    localparam int BOX_WIDTH = 31;

    localparam logic [2:0] ADDR_BOX_X = 3'd0;
    localparam logic [2:0] ADDR_BOX_Y = 3'd1;
    localparam logic [2:0] ADDR_BOX_Z = 3'd2;
    localparam logic [2:0] ADDR_REF_X = 3'd3;
    localparam logic [2:0] ADDR_REF_Y = 3'd4;
    localparam logic [2:0] ADDR_REF_Z = 3'd5;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DIV  = 2'd1,
        BK_FIX  = 2'd2,
        BK_OUT  = 2'd3
    } bk_state_t;

endpackage

### design/cpg_front.sv
// ---------------------------------------------------------------------------
// cpg_front
// Input stage and two-entry queue that holds accepted atom positions.
// ---------------------------------------------------------------------------
module cpg_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_pos_x,
    input  logic signed [COORD_WIDTH-1:0] s_pos_y,
    input  logic signed [COORD_WIDTH-1:0] s_pos_z,
    input  logic                          s_first_atom,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic [3*COORD_WIDTH:0]        q_data
);
    import cpg_pkg::*;

    localparam int DW = 3 * COORD_WIDTH + 1;

    logic [DW-1:0] mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= {s_first_atom, s_pos_z, s_pos_y, s_pos_x};
        end
    end

endmodule

### design/cpg_divider.sv
// ---------------------------------------------------------------------------
// cpg_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module cpg_divider #(
    parameter int NUM_WIDTH = 33,
    parameter int DEN_WIDTH = 31
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NUM_WIDTH-1:0] numer,
    input  logic [DEN_WIDTH-1:0] denom,
    output logic                 done,
    output logic [NUM_WIDTH-1:0] quot,
    output logic [DEN_WIDTH-1:0] rem
);
    import cpg_pkg::*;

    localparam int CW = $clog2(NUM_WIDTH + 1);

    logic [NUM_WIDTH-1:0] q_reg, q_next;
    logic [DEN_WIDTH:0]   r_reg, r_next;
    logic [DEN_WIDTH-1:0] d_reg;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DEN_WIDTH+1:0] trial;

    always_comb begin
        trial     = {r_reg, q_reg[NUM_WIDTH-1]} - {2'b00, d_reg};
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = numer;
            r_next    = '0;
            cnt_next  = CW'(NUM_WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DEN_WIDTH+1]) begin
                r_next = trial[DEN_WIDTH:0];
                q_next = {q_reg[NUM_WIDTH-2:0], 1'b1};
            end else begin
                r_next = {r_reg[DEN_WIDTH-1:0], q_reg[NUM_WIDTH-1]};
                q_next = {q_reg[NUM_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start) begin
            d_reg <= denom;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg[DEN_WIDTH-1:0];

endmodule

### design/cpg_back.sv
// ---------------------------------------------------------------------------
// cpg_back
// Per-axis wrap sequencer with shared divider, chain state and output register.
// ---------------------------------------------------------------------------
module cpg_back #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [3*COORD_WIDTH:0]        q_data,
    input  logic [cpg_pkg::BOX_WIDTH-1:0] box_x,
    input  logic [cpg_pkg::BOX_WIDTH-1:0] box_y,
    input  logic [cpg_pkg::BOX_WIDTH-1:0] box_z,
    input  logic signed [COORD_WIDTH-1:0] ref_x,
    input  logic signed [COORD_WIDTH-1:0] ref_y,
    input  logic signed [COORD_WIDTH-1:0] ref_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_out_x,
    output logic signed [COORD_WIDTH-1:0] m_out_y,
    output logic signed [COORD_WIDTH-1:0] m_out_z,
    output logic                          m_zero_box_error
);
    import cpg_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DW = COORD_WIDTH + 1;
    localparam int EW = COORD_WIDTH + 2;

    bk_state_t state_reg, state_next;
    axis_t     axis_reg, axis_next;

    logic signed [CW-1:0] pos_reg [3];
    logic signed [CW-1:0] anc_reg [3];
    logic signed [CW-1:0] prev_reg [3];
    logic signed [CW-1:0] res_reg [3];
    logic                 err_reg;
    logic                 neg_reg;
    logic                 ovalid_reg, ovalid_next;

    logic signed [CW-1:0] item_pos [3];
    logic                 item_first;
    logic signed [DW-1:0] diff;
    logic [DW-1:0]        mag;
    logic [BOX_WIDTH-1:0] box_sel;
    logic                 div_start, div_done;
    logic [DW-1:0]        div_q;
    logic [BOX_WIDTH-1:0] div_r;
    logic                 up;
    logic signed [EW-1:0] wrapped, sum;
    logic signed [CW-1:0] clamped;
    logic                 take;
    logic                 out_free;

    assign item_pos[0] = q_data[CW-1:0];
    assign item_pos[1] = q_data[2*CW-1:CW];
    assign item_pos[2] = q_data[3*CW-1:2*CW];
    assign item_first  = q_data[3*CW];

    assign out_free = !ovalid_reg || m_ready;
    assign q_ready  = (state_reg == BK_IDLE);
    assign take     = q_valid && q_ready;

    always_comb begin
        case (axis_reg)
            AXIS_X:  box_sel = box_x;
            AXIS_Y:  box_sel = box_y;
            default: box_sel = box_z;
        endcase
    end

    assign diff = DW'(pos_reg[axis_reg]) - DW'(anc_reg[axis_reg]);
    assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);

    assign up = ({1'b0, div_r, 1'b0} > {2'b00, box_sel})
             || (({div_r, 1'b0} == {1'b0, box_sel}) && div_q[0]);

    always_comb begin
        wrapped = up ? (EW'(div_r) - EW'(box_sel)) : EW'(div_r);
        if (neg_reg) begin
            wrapped = -wrapped;
        end
        sum = EW'(anc_reg[axis_reg]) + wrapped;
        if (sum[EW-1:CW-1] == '0 || sum[EW-1:CW-1] == '1) begin
            clamped = sum[CW-1:0];
        end else if (sum[EW-1]) begin
            clamped = {1'b1, {(CW-1){1'b0}}};
        end else begin
            clamped = {1'b0, {(CW-1){1'b1}}};
        end
    end

    cpg_divider #(
        .NUM_WIDTH(DW),
        .DEN_WIDTH(BOX_WIDTH)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .numer  (mag),
        .denom  (box_sel),
        .done   (div_done),
        .quot   (div_q),
        .rem    (div_r)
    );

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            BK_IDLE: begin
                if (take) begin
                    axis_next  = AXIS_X;
                    state_next = (box_x == '0 || box_y == '0 || box_z == '0) ? BK_OUT
                                                                              : BK_DIV;
                end
            end
            BK_DIV: begin
                state_next = BK_FIX;
            end
            BK_FIX: begin
                if (div_done) begin
                    if (axis_reg == AXIS_Z) begin
                        state_next = BK_OUT;
                    end else begin
                        axis_next  = axis_t'(axis_reg + 2'd1);
                        state_next = BK_DIV;
                    end
                end
            end
            BK_OUT: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        div_start   = (state_reg == BK_DIV);
        ovalid_next = ovalid_reg;
        if (m_ready) begin
            ovalid_next = 1'b0;
        end
        if (state_reg == BK_OUT && out_free) begin
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= BK_IDLE;
            axis_reg   <= AXIS_X;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                prev_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            ovalid_reg <= ovalid_next;
            if (state_reg == BK_OUT && out_free) begin
                for (int i = 0; i < 3; i++) begin
                    prev_reg[i] <= res_reg[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            err_reg    <= (box_x == '0 || box_y == '0 || box_z == '0);
            pos_reg[0] <= item_pos[0];
            pos_reg[1] <= item_pos[1];
            pos_reg[2] <= item_pos[2];
            anc_reg[0] <= item_first ? ref_x : prev_reg[0];
            anc_reg[1] <= item_first ? ref_y : prev_reg[1];
            anc_reg[2] <= item_first ? ref_z : prev_reg[2];
            res_reg[0] <= item_pos[0];
            res_reg[1] <= item_pos[1];
            res_reg[2] <= item_pos[2];
        end
        if (state_reg == BK_DIV) begin
            neg_reg <= diff[DW-1];
        end
        if (state_reg == BK_FIX && div_done) begin
            res_reg[axis_reg] <= clamped;
        end
        if (state_reg == BK_OUT && out_free) begin
            m_out_x          <= res_reg[0];
            m_out_y          <= res_reg[1];
            m_out_z          <= res_reg[2];
            m_zero_box_error <= err_reg;
        end
    end

    assign m_valid = ovalid_reg;

endmodule

### design/chained_periodic_gather.sv
// ---------------------------------------------------------------------------
// chained_periodic_gather
// Minimum image gather of atom positions in a rectangular periodic box.
// ---------------------------------------------------------------------------
// The s_ channel takes one atom position per transaction with a flag that
// marks the first atom of a molecule. The m_ channel returns one gathered
// position per transaction, with an error flag when a box length is zero.
// Box lengths and the reference point are to be set through the APB port
// only while the block is idle; the block itself does not enforce this.
// Each axis runs through one shared radix-2 divider, one quotient bit per
// cycle over COORD_WIDTH+1 bits, started in the DIV state and awaited in
// the FIX state. The back end takes no new item until the result of the
// last one has gone into the output register. With a zero box length an
// item skips the divider and goes straight to the output state. A two-entry
// input queue accepts items while the back end works, and the output
// register holds a result until the receiver takes it. When the receiver
// stalls, the back end waits with its next result and the queue fills, then
// s_ready falls. Reset clears the registers, the chained previous position
// and all handshake state.
// ---------------------------------------------------------------------------
module chained_periodic_gather #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_pos_x,
    input  logic signed [COORD_WIDTH-1:0] s_pos_y,
    input  logic signed [COORD_WIDTH-1:0] s_pos_z,
    input  logic                          s_first_atom,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_out_x,
    output logic signed [COORD_WIDTH-1:0] m_out_y,
    output logic signed [COORD_WIDTH-1:0] m_out_z,
    output logic                          m_zero_box_error
);
    import cpg_pkg::*;

    logic [BOX_WIDTH-1:0]   box_x_reg, box_y_reg, box_z_reg;
    logic [COORD_WIDTH-1:0] ref_x_reg, ref_y_reg, ref_z_reg;
    logic                   q_valid, q_ready;
    logic [3*COORD_WIDTH:0] q_data;
    logic                   wr_en;
    logic [2:0]             reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_x_reg <= '0;
            box_y_reg <= '0;
            box_z_reg <= '0;
            ref_x_reg <= '0;
            ref_y_reg <= '0;
            ref_z_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                ADDR_BOX_X: box_x_reg <= pwdata[BOX_WIDTH-1:0];
                ADDR_BOX_Y: box_y_reg <= pwdata[BOX_WIDTH-1:0];
                ADDR_BOX_Z: box_z_reg <= pwdata[BOX_WIDTH-1:0];
                ADDR_REF_X: ref_x_reg <= COORD_WIDTH'(pwdata);
                ADDR_REF_Y: ref_y_reg <= COORD_WIDTH'(pwdata);
                ADDR_REF_Z: ref_z_reg <= COORD_WIDTH'(pwdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ADDR_BOX_X: prdata = {1'b0, box_x_reg};
            ADDR_BOX_Y: prdata = {1'b0, box_y_reg};
            ADDR_BOX_Z: prdata = {1'b0, box_z_reg};
            ADDR_REF_X: prdata = 32'(ref_x_reg);
            ADDR_REF_Y: prdata = 32'(ref_y_reg);
            ADDR_REF_Z: prdata = 32'(ref_z_reg);
            default:    prdata = '0;
        endcase
    end

    cpg_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_pos_z     (s_pos_z),
        .s_first_atom(s_first_atom),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_data      (q_data)
    );

    cpg_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_data          (q_data),
        .box_x           (box_x_reg),
        .box_y           (box_y_reg),
        .box_z           (box_z_reg),
        .ref_x           (ref_x_reg),
        .ref_y           (ref_y_reg),
        .ref_z           (ref_z_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_x         (m_out_x),
        .m_out_y         (m_out_y),
        .m_out_z         (m_out_z),
        .m_zero_box_error(m_zero_box_error)
    );

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_out_y))
        else $error("result changed while stalled");

    a_queue_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready && !q_valid |=> !m_valid || $past(m_valid))
        else $error("result appeared without an item");

    a_err_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_zero_box_error |-> box_x_reg != '0)
        else $error("wrap done with zero box");

endmodule

### sim/cpg_checker.sv
// ---------------------------------------------------------------------------
// cpg_checker
// Predicts and checks the gathered positions of the chained periodic gather.
// ---------------------------------------------------------------------------
// Watches the APB writes, the input and the result channels. For every
// accepted input transaction it computes the nearest periodic image to the
// anchor (the position itself for a zero box) and queues it; every result
// transaction is compared with the oldest queued position.
// ---------------------------------------------------------------------------
module cpg_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic               s_first_atom,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_out_x,
    input  logic signed [31:0] m_out_y,
    input  logic signed [31:0] m_out_z,
    input  logic               m_zero_box_error,
    output int                 fail_count,
    output int                 pending,
    output int                 gathered_count,
    output int                 error_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import cpg_pkg::*;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               err;
    } gathered_t;

    logic [30:0]        box_len [3];
    logic signed [31:0] ref_pt [3];
    logic signed [31:0] chain_pos [3];
    gathered_t          gathered_q [$];

    function automatic logic signed [31:0] nearest_image(
        logic signed [31:0] anchor, logic signed [31:0] pos, logic [30:0] box);
        longint d, mag, q, r, a, s;
        d = longint'(pos) - longint'(anchor);
        mag = d < 0 ? -d : d;
        q = mag / longint'(box);
        r = mag % longint'(box);
        if (2 * r > longint'(box) || (2 * r == longint'(box) && q[0]))
            a = r - longint'(box);
        else
            a = r;
        if (d < 0)
            a = -a;
        s = longint'(anchor) + a;
        if (s > 64'sd2147483647)
            s = 64'sd2147483647;
        if (s < -64'sd2147483648)
            s = -64'sd2147483648;
        return s[31:0];
    endfunction

    always @(posedge aclk) begin
        gathered_t exp_g, got;
        logic signed [31:0] pos [3];
        logic signed [31:0] anchor;
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                box_len[i] = '0;
                ref_pt[i] = '0;
                chain_pos[i] = '0;
            end
            gathered_q.delete();
            fail_count <= 0;
            pending <= 0;
            gathered_count <= 0;
            error_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    ADDR_BOX_X: box_len[0] = pwdata[30:0];
                    ADDR_BOX_Y: box_len[1] = pwdata[30:0];
                    ADDR_BOX_Z: box_len[2] = pwdata[30:0];
                    ADDR_REF_X: ref_pt[0] = pwdata;
                    ADDR_REF_Y: ref_pt[1] = pwdata;
                    ADDR_REF_Z: ref_pt[2] = pwdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                pos[0] = s_pos_x;
                pos[1] = s_pos_y;
                pos[2] = s_pos_z;
                exp_g.err = box_len[0] == 0 || box_len[1] == 0 || box_len[2] == 0;
                for (int i = 0; i < 3; i++) begin
                    anchor = s_first_atom ? ref_pt[i] : chain_pos[i];
                    chain_pos[i] = exp_g.err ? pos[i]
                                             : nearest_image(anchor, pos[i], box_len[i]);
                end
                exp_g.x = chain_pos[0];
                exp_g.y = chain_pos[1];
                exp_g.z = chain_pos[2];
                gathered_q = {gathered_q, exp_g};
            end
            if (m_valid && m_ready) begin
                got = '{m_out_x, m_out_y, m_out_z, m_zero_box_error};
                gathered_count <= gathered_count + 1;
                if (m_zero_box_error)
                    error_count <= error_count + 1;
                if (gathered_q.size() == 0) begin
                    $display("%t: unexpected result x=%h y=%h z=%h err=%b",
                             $time, got.x, got.y, got.z, got.err);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_g = gathered_q.pop_front();
                    if (got !== exp_g) begin
                        $display("%t: mismatch expected x=%h y=%h z=%h err=%b",
                                 $time, exp_g.x, exp_g.y, exp_g.z, exp_g.err);
                        $display("%t:          actual   x=%h y=%h z=%h err=%b",
                                 $time, got.x, got.y, got.z, got.err);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= gathered_q.size();
        end
    end

endmodule

### sim/tb_chained_periodic_gather.sv
// ---------------------------------------------------------------------------
// tb_chained_periodic_gather
// Stimulus and verdict for the chained periodic gather block.
// ---------------------------------------------------------------------------
// Programs several box and reference settings through APB, among them zero
// and full-scale lengths, and sends directed then random molecules of atom
// positions with random gaps and receiver stalls. The checker compares all
// results.
// ---------------------------------------------------------------------------
module tb_chained_periodic_gather;
    timeunit 1ns;
    timeprecision 1ps;
    import cpg_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_pos_x;
    logic signed [31:0] s_pos_y;
    logic signed [31:0] s_pos_z;
    logic               s_first_atom;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_out_x;
    logic signed [31:0] m_out_y;
    logic signed [31:0] m_out_z;
    logic               m_zero_box_error;
    int                 fail_count;
    int                 pending;
    int                 gathered_count;
    int                 error_count;
    int                 sent_count;
    int                 idle_cycles;
    bit                 hold_off;

    chained_periodic_gather i_dut (.*);

    cpg_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 150);
        return $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 4);
    endfunction

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 3) == 0 ? 32'sh7fffffff : -32'sh80000000;
            default: return $signed($urandom_range(0, 32'h0fffffff)) - 32'sh08000000;
        endcase
    endfunction

    task automatic apb_write(logic [2:0] reg_idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_geometry(logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                                logic [31:0] rx, logic [31:0] ry, logic [31:0] rz);
        apb_write(ADDR_BOX_X, bx);
        apb_write(ADDR_BOX_Y, by);
        apb_write(ADDR_BOX_Z, bz);
        apb_write(ADDR_REF_X, rx);
        apb_write(ADDR_REF_Y, ry);
        apb_write(ADDR_REF_Z, rz);
    endtask

    task automatic send_atom(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic first);
        s_valid <= 1'b1;
        s_pos_x <= x;
        s_pos_y <= y;
        s_pos_z <= z;
        s_first_atom <= first;
        do
            @(posedge aclk);
        while (!s_ready);
        sent_count++;
    endtask

    task automatic pause(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic random_molecules(int count, int mode);
        int n, len;
        logic signed [31:0] x, y, z;
        n = 0;
        while (n < count) begin
            len = $urandom_range(1, 8);
            x = rand_coord(mode);
            y = rand_coord(mode);
            z = rand_coord(mode);
            for (int k = 0; k < len && n < count; k++) begin
                if ($urandom_range(0, 15) == 0)
                    send_atom(rand_coord(0), rand_coord(1), rand_coord(0),
                              1'($urandom_range(0, 1)));
                else
                    send_atom(x + $signed($urandom_range(0, 4095)) - 2048,
                              y + $signed($urandom_range(0, 4095)) - 2048,
                              z + $signed($urandom_range(0, 4095)) - 2048, k == 0);
                n++;
                pause(gap_len());
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            if ($urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat (gap_len() + 1) @(posedge aclk);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel)
                idle_cycles = 0;
            else if (++idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", pending);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        hold_off = 1'b0;
        sent_count = 0;
        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_valid <= 1'b0;
        s_pos_x <= '0;
        s_pos_y <= '0;
        s_pos_z <= '0;
        s_first_atom <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero box lengths after reset: positions pass through.
        send_atom(32'sh7fffffff, -32'sh80000000, 32'sh00123456, 1'b0);
        send_atom(-32'sh80000000, 32'sh7fffffff, 32'sh0, 1'b1);
        drain();
        set_geometry(32'h0010_0000, 32'h0, 32'h0030_0000, 32'h0, 32'h0, 32'h0);
        send_atom(32'sh0, 32'sh1, 32'sh2, 1'b1);
        drain();

        // Ties to even, full-scale and unit boxes, saturation, chaining.
        set_geometry(32'h0000_0004, 32'h7fff_ffff, 32'h0000_0001,
                     32'h0, 32'h7fff_ffff, 32'h8000_0000);
        send_atom(32'sh2, 32'sh0, 32'sh5, 1'b1);
        send_atom(32'sh6, -32'sh80000000, -32'sh7, 1'b0);
        send_atom(-32'sh2, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
        send_atom(-32'sh6, -32'sh80000000, -32'sh80000000, 1'b1);
        send_atom(32'sh7fffffff, -32'sh80000000, 32'sh7fffffff, 1'b0);
        send_atom(-32'sh80000000, 32'sh7fffffff, -32'sh80000000, 1'b0);
        send_atom(32'sh3, 32'sh3fffffff, 32'sh0, 1'b1);
        drain();
        set_geometry(32'h7fff_ffff, 32'h0000_0003, 32'h4000_0000,
                     32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        send_atom(-32'sh80000000, 32'sh7fffffff, 32'sh40000000, 1'b1);
        send_atom(32'sh7fffffff, -32'sh80000000, -32'sh40000000, 1'b0);
        send_atom(32'sh0, 32'sh4, 32'sh20000000, 1'b0);
        send_atom(-32'sh1, -32'sh4, -32'sh20000000, 1'b1);
        drain();

        // Random phases over several box settings.
        set_geometry(32'h0140_0000, 32'h00c8_0000, 32'h0100_0000,
                     32'h00a0_0000, 32'hff80_0000, 32'h0);
        random_molecules(150, 2);
        drain();
        set_geometry($urandom_range(1, 32'h7fffffff), $urandom_range(1, 255),
                     $urandom_range(1, 32'h7fffffff), $urandom, $urandom, $urandom);
        random_molecules(150, 0);
        drain();
        // Long receiver stall while the sender keeps offering.
        hold_off = 1'b1;
        set_geometry(32'h7fff_ffff, 32'h0000_1000, 32'h0020_0000,
                     32'h8000_0000, 32'h7fff_ffff, $urandom);
        random_molecules(150, 1);
        drain();
        set_geometry($urandom_range(1, 32'h00ffffff), $urandom_range(1, 32'h00ffffff),
                     $urandom_range(0, 1) ? 32'h0 : 32'h10, $urandom, $urandom, $urandom);
        random_molecules(150, 2);
        drain();

        $display("Sent %0d atoms in molecules over several box settings; %0d results,",
                 sent_count, gathered_count);
        $display("%0d of them flagged for a zero box length.", error_count);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
